// ===== rtl/tdch_pkg.sv =====
// Shared types and constants for the tile distinct-color histogram block.
`default_nettype none

package tdch_pkg;

  // Defaults of the top-level parameters
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;
  localparam int CELL_SIZE_DEF  = 8;

  // Fixed field widths
  localparam int PIX_W      = 8;
  localparam int PALETTE    = 256;
  localparam int DISTINCT_W = 7;
  localparam int TOTAL_W    = 17;
  localparam int NUM_BINS   = 64;
  localparam int BIN_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int DIM_RESET  = 256;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // Position flags of one pixel, front to back
  typedef struct packed {
    logic cell_first;
    logic cell_last;
    logic frame_end;
  } pix_flags_t;

endpackage : tdch_pkg

`default_nettype wire

// ===== rtl/tdch_if.sv =====
// Handshake channel interfaces: pixel input, histogram bin output, config write.
`default_nettype none

interface tdch_pix_if;
  logic                        valid;
  logic                        ready;
  logic [tdch_pkg::PIX_W-1:0]  pixel_index;
  modport source (output valid, output pixel_index, input ready);
  modport sink (input valid, input pixel_index, output ready);
endinterface : tdch_pix_if

interface tdch_bin_if;
  logic                             valid;
  logic                             ready;
  logic [tdch_pkg::DISTINCT_W-1:0]  distinct_colors;
  logic [tdch_pkg::TOTAL_W-1:0]     cell_total;
  logic                             last_bin;
  modport source (output valid, output distinct_colors, output cell_total,
                  output last_bin, input ready);
  modport sink (input valid, input distinct_colors, input cell_total,
                input last_bin, output ready);
endinterface : tdch_bin_if

interface tdch_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tdch_pkg::CFG_IDX_W-1:0]   index;
  logic [tdch_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface : tdch_cfg_if

`default_nettype wire

// ===== rtl/tile_distinct_color_histogram.sv =====
// Top level: config registers, pixel front end, queue and counting back end.
// Per pixel the back end reads the map RAM, then updates and writes it back;
// the last pixel of each cell adds a histogram RAM increment.
// A frame's final pixel starts the dump: 64 bins, each a histogram RAM read and then
// an output load; the dump also waits on the queue ahead of it and on output stalls.
// rst_n is synchronous: position, queue, histogram valid bits and output clear;
// width and height return to 256. Per-cell maps need no clearing.
`default_nettype none

module tile_distinct_color_histogram #(
  parameter int MAX_WIDTH  = tdch_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tdch_pkg::MAX_HEIGHT_DEF,
  parameter int CELL_SIZE  = tdch_pkg::CELL_SIZE_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tdch_pix_if.sink   in_if,
  tdch_bin_if.source out_if,
  tdch_cfg_if.sink   cfg_if
);

  localparam int CELL_COLS = (MAX_WIDTH + CELL_SIZE - 1) / CELL_SIZE;
  localparam int CELL_W    = (CELL_COLS > 1) ? $clog2(CELL_COLS) : 1;
  localparam int Q_W       = tdch_pkg::PIX_W + CELL_W + $bits(tdch_pkg::pix_flags_t);

  logic [tdch_pkg::CFG_DATA_W-1:0] width_r;
  logic [tdch_pkg::CFG_DATA_W-1:0] height_r;
  logic                            cfg_wr;

  logic                            push;
  logic [tdch_pkg::PIX_W-1:0]      push_pix;
  logic [CELL_W-1:0]               push_cell;
  tdch_pkg::pix_flags_t            push_flags;
  logic                            pop;
  logic [Q_W-1:0]                  head_data;
  logic                            q_empty;
  logic                            q_full;
  logic [tdch_pkg::PIX_W-1:0]      head_pix;
  logic [CELL_W-1:0]               head_cell;
  tdch_pkg::pix_flags_t            head_flags;

  assign cfg_if.ready = 1'b1;
  assign cfg_wr       = cfg_if.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= tdch_pkg::CFG_DATA_W'(tdch_pkg::DIM_RESET);
      height_r <= tdch_pkg::CFG_DATA_W'(tdch_pkg::DIM_RESET);
    end else if (cfg_wr) begin
      case (cfg_if.index)
        tdch_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_if.data;
        tdch_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  tdch_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CELL_SIZE  (CELL_SIZE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_wr),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .in_if      (in_if),
    .push       (push),
    .push_pix   (push_pix),
    .push_cell  (push_cell),
    .push_flags (push_flags),
    .queue_full (q_full)
  );

  tdch_fifo #(.WIDTH(Q_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_pix, push_cell, push_flags}),
    .pop       (pop),
    .head_data (head_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign {head_pix, head_cell, head_flags} = head_data;

  tdch_back #(
    .CELL_COLS (CELL_COLS),
    .CELL_SIZE (CELL_SIZE)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (cfg_wr),
    .queue_empty (q_empty),
    .head_pix    (head_pix),
    .head_cell   (head_cell),
    .head_flags  (head_flags),
    .pop         (pop),
    .out_if      (out_if)
  );

endmodule : tile_distinct_color_histogram

`default_nettype wire

// ===== rtl/tdch_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tdch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : tdch_ram

`default_nettype wire

// ===== rtl/tdch_fifo.sv =====
// Two-entry queue between the pixel front end and the counting back end.
`default_nettype none

module tdch_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] head_data,
  output logic                  empty,
  output logic                  full
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wptr_r, wptr_nxt;
  logic             rptr_r, rptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign empty     = (cnt_r == 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign head_data = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = ~wptr_r;
    end
    if (pop) begin
      rptr_nxt = ~rptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule : tdch_fifo

`default_nettype wire

// ===== rtl/tdch_front.sv =====
// Front end: accepts pixels, tracks column/row/cell position, flags cell and frame ends.
`default_nettype none

module tdch_front #(
  parameter int MAX_WIDTH  = tdch_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tdch_pkg::MAX_HEIGHT_DEF,
  parameter int CELL_SIZE  = tdch_pkg::CELL_SIZE_DEF,
  localparam int CELL_COLS = (MAX_WIDTH + CELL_SIZE - 1) / CELL_SIZE,
  localparam int CELL_W    = (CELL_COLS > 1) ? $clog2(CELL_COLS) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              restart,
  input  wire logic [tdch_pkg::CFG_DATA_W-1:0]   cfg_width,
  input  wire logic [tdch_pkg::CFG_DATA_W-1:0]   cfg_height,
  tdch_pix_if.sink                               in_if,
  output logic                                   push,
  output logic [tdch_pkg::PIX_W-1:0]             push_pix,
  output logic [CELL_W-1:0]                      push_cell,
  output tdch_pkg::pix_flags_t                   push_flags,
  input  wire logic                              queue_full
);

  localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int OFF_W  = $clog2(CELL_SIZE);
  localparam int WEXT_W = (WDIM_W > tdch_pkg::CFG_DATA_W) ? WDIM_W : tdch_pkg::CFG_DATA_W;
  localparam int HEXT_W = (HDIM_W > tdch_pkg::CFG_DATA_W) ? HDIM_W : tdch_pkg::CFG_DATA_W;
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(CELL_SIZE - 1);

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [OFF_W-1:0]  col_off_r, col_off_nxt;
  logic [OFF_W-1:0]  row_off_r, row_off_nxt;
  logic [CELL_W-1:0] cell_r, cell_nxt;

  logic [WEXT_W-1:0] w_ext;
  logic [HEXT_W-1:0] h_ext;
  logic [WDIM_W-1:0] w_eff;
  logic [HDIM_W-1:0] h_eff;
  logic              accept;
  logic              line_end;
  logic              row_last;
  logic              frame_end;

  // Zero reads as one, oversize clamps to the maximum
  always_comb begin
    w_ext = WEXT_W'(cfg_width);
    h_ext = HEXT_W'(cfg_height);
    if (cfg_width == '0) begin
      w_eff = WDIM_W'(1);
    end else if (w_ext > WEXT_W'(MAX_WIDTH)) begin
      w_eff = WDIM_W'(MAX_WIDTH);
    end else begin
      w_eff = WDIM_W'(w_ext);
    end
    if (cfg_height == '0) begin
      h_eff = HDIM_W'(1);
    end else if (h_ext > HEXT_W'(MAX_HEIGHT)) begin
      h_eff = HDIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = HDIM_W'(h_ext);
    end
  end

  assign in_if.ready = !queue_full;
  assign accept      = in_if.valid && !queue_full;

  assign line_end  = (WDIM_W'(col_r) + WDIM_W'(1)) >= w_eff;
  assign row_last  = (HDIM_W'(row_r) + HDIM_W'(1)) >= h_eff;
  assign frame_end = line_end && row_last;

  assign push                  = accept;
  assign push_pix              = in_if.pixel_index;
  assign push_cell             = cell_r;
  assign push_flags.cell_first = (col_off_r == '0) && (row_off_r == '0);
  assign push_flags.cell_last  = (line_end || (col_off_r == OFF_LAST)) &&
                                 (row_last || (row_off_r == OFF_LAST));
  assign push_flags.frame_end  = frame_end;

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    col_off_nxt = col_off_r;
    row_off_nxt = row_off_r;
    cell_nxt    = cell_r;
    if (restart) begin
      col_nxt     = '0;
      row_nxt     = '0;
      col_off_nxt = '0;
      row_off_nxt = '0;
      cell_nxt    = '0;
    end else if (accept) begin
      if (!line_end) begin
        col_nxt = col_r + COL_W'(1);
        if (col_off_r == OFF_LAST) begin
          col_off_nxt = '0;
          cell_nxt    = cell_r + CELL_W'(1);
        end else begin
          col_off_nxt = col_off_r + OFF_W'(1);
        end
      end else begin
        col_nxt     = '0;
        col_off_nxt = '0;
        cell_nxt    = '0;
        if (!row_last) begin
          row_nxt     = row_r + ROW_W'(1);
          row_off_nxt = (row_off_r == OFF_LAST) ? '0 : row_off_r + OFF_W'(1);
        end else begin
          row_nxt     = '0;
          row_off_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      col_off_r <= '0;
      row_off_r <= '0;
      cell_r    <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      col_off_r <= col_off_nxt;
      row_off_r <= row_off_nxt;
      cell_r    <= cell_nxt;
    end
  end

endmodule : tdch_front

`default_nettype wire

// ===== rtl/tdch_back.sv =====
// Back end: per-cell distinct-index maps, histogram update and end-of-frame dump.
`default_nettype none

module tdch_back #(
  parameter int CELL_COLS = 256,
  parameter int CELL_SIZE = tdch_pkg::CELL_SIZE_DEF,
  localparam int CELL_W   = (CELL_COLS > 1) ? $clog2(CELL_COLS) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   restart,
  input  wire logic                   queue_empty,
  input  wire logic [tdch_pkg::PIX_W-1:0] head_pix,
  input  wire logic [CELL_W-1:0]      head_cell,
  input  wire tdch_pkg::pix_flags_t   head_flags,
  output logic                        pop,
  tdch_bin_if.source                  out_if
);

  localparam int MAX_DISTINCT = (CELL_SIZE * CELL_SIZE < tdch_pkg::PALETTE) ?
                                CELL_SIZE * CELL_SIZE : tdch_pkg::PALETTE;
  localparam int CNT_W   = $clog2(MAX_DISTINCT + 1);
  localparam int MAP_W   = tdch_pkg::PALETTE;
  localparam int ENTRY_W = MAP_W + CNT_W;
  localparam int BIN_W   = tdch_pkg::BIN_W;
  localparam int TOT_W   = tdch_pkg::TOTAL_W;

  typedef enum logic [2:0] {
    S_PIX,
    S_UPD,
    S_HINC,
    S_DRD,
    S_DLD
  } state_t;

  state_t                      state_r;
  logic [tdch_pkg::PIX_W-1:0]  pix_r;
  logic [CELL_W-1:0]           cell_r;
  tdch_pkg::pix_flags_t        flags_r;
  logic [BIN_W-1:0]            bin_r;
  logic [tdch_pkg::NUM_BINS-1:0] hvalid_r;
  logic                        out_vld_r;
  logic [tdch_pkg::DISTINCT_W-1:0] out_distinct_r;
  logic [TOT_W-1:0]            out_total_r;
  logic                        out_last_r;

  // map RAM
  logic               map_we;
  logic [ENTRY_W-1:0] map_wdata;
  logic [ENTRY_W-1:0] map_rdata;
  logic [MAP_W-1:0]   map_old;
  logic [MAP_W-1:0]   map_new;
  logic [CNT_W-1:0]   cnt_old;
  logic [CNT_W-1:0]   cnt_new;
  logic               seen;

  // histogram RAM
  logic               hist_we;
  logic [BIN_W-1:0]   hist_raddr;
  logic [TOT_W-1:0]   hist_wdata;
  logic [TOT_W-1:0]   hist_rdata;
  logic [TOT_W-1:0]   hist_cur;
  logic [BIN_W-1:0]   bin_nxt;
  logic               out_free;

  tdch_ram #(.WIDTH(ENTRY_W), .DEPTH(CELL_COLS)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (cell_r),
    .wdata (map_wdata),
    .raddr (head_cell),
    .rdata (map_rdata)
  );

  tdch_ram #(.WIDTH(TOT_W), .DEPTH(tdch_pkg::NUM_BINS)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (bin_r),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // First pixel of a cell starts from an empty map
  always_comb begin
    map_old   = flags_r.cell_first ? '0 : map_rdata[MAP_W-1:0];
    cnt_old   = flags_r.cell_first ? '0 : map_rdata[ENTRY_W-1:MAP_W];
    seen      = map_old[pix_r];
    map_new   = map_old;
    map_new[pix_r] = 1'b1;
    cnt_new   = seen ? cnt_old : cnt_old + CNT_W'(1);
    map_wdata = {cnt_new, map_new};
    map_we    = (state_r == S_UPD);
    if (int'(cnt_new) > tdch_pkg::NUM_BINS) begin
      bin_nxt = BIN_W'(tdch_pkg::NUM_BINS - 1);
    end else if (cnt_new == '0) begin
      bin_nxt = '0;
    end else begin
      bin_nxt = BIN_W'(cnt_new - CNT_W'(1));
    end
  end

  // Bins not written this frame read as zero
  assign hist_cur   = hvalid_r[bin_r] ? hist_rdata : '0;
  assign hist_wdata = (hist_cur == '1) ? hist_cur : hist_cur + TOT_W'(1);
  assign hist_we    = (state_r == S_HINC);
  assign hist_raddr = (state_r == S_UPD) ? bin_nxt : bin_r;

  assign out_free = !out_vld_r || out_if.ready;
  assign pop      = (state_r == S_PIX) && !queue_empty;

  assign out_if.valid           = out_vld_r;
  assign out_if.distinct_colors = out_distinct_r;
  assign out_if.cell_total      = out_total_r;
  assign out_if.last_bin        = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_PIX;
      hvalid_r  <= '0;
      out_vld_r <= 1'b0;
      bin_r     <= '0;
    end else begin
      if (out_vld_r && out_if.ready) begin
        out_vld_r <= 1'b0;
      end
      if (restart) begin
        hvalid_r <= '0;
      end
      case (state_r)
        S_PIX: begin
          if (!queue_empty) begin
            pix_r   <= head_pix;
            cell_r  <= head_cell;
            flags_r <= head_flags;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          bin_r <= bin_nxt;
          if (flags_r.cell_last) begin
            state_r <= S_HINC;
          end else begin
            state_r <= S_PIX;
          end
        end
        S_HINC: begin
          hvalid_r[bin_r] <= 1'b1;
          if (flags_r.frame_end) begin
            bin_r   <= '0;
            state_r <= S_DRD;
          end else begin
            state_r <= S_PIX;
          end
        end
        S_DRD: begin
          // read issued here; the output stage is free when the data lands
          if (out_free) begin
            state_r <= S_DLD;
          end
        end
        S_DLD: begin
          out_vld_r      <= 1'b1;
          out_distinct_r <= tdch_pkg::DISTINCT_W'(bin_r) + tdch_pkg::DISTINCT_W'(1);
          out_total_r    <= hist_cur;
          out_last_r     <= (bin_r == BIN_W'(tdch_pkg::NUM_BINS - 1));
          if (bin_r == BIN_W'(tdch_pkg::NUM_BINS - 1)) begin
            hvalid_r <= '0;
            state_r  <= S_PIX;
          end else begin
            bin_r   <= bin_r + BIN_W'(1);
            state_r <= S_DRD;
          end
        end
        default: begin
          state_r <= S_PIX;
        end
      endcase
    end
  end

endmodule : tdch_back

`default_nettype wire

// ===== rtl/tdch_chk.sv =====
// Port-level checker for the histogram output stream, bound to the top level.
`default_nettype none

module tdch_chk (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic [tdch_pkg::DISTINCT_W-1:0]      out_distinct,
  input wire logic [tdch_pkg::TOTAL_W-1:0]         out_total,
  input wire logic                                 out_last
);

  logic [tdch_pkg::DISTINCT_W-1:0] exp_bin_r;

  // next bin expected in the dump
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_bin_r <= tdch_pkg::DISTINCT_W'(1);
    end else if (out_valid && out_ready) begin
      exp_bin_r <= out_last ? tdch_pkg::DISTINCT_W'(1) :
                              exp_bin_r + tdch_pkg::DISTINCT_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distinct) &&
                                $stable(out_total) && $stable(out_last))
    else $error("output item changed while stalled");

  a_bin_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distinct == exp_bin_r)
    else $error("histogram bins out of order");

  a_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_distinct == tdch_pkg::DISTINCT_W'(tdch_pkg::NUM_BINS))))
    else $error("last_bin not on the final bin");

endmodule : tdch_chk

bind tile_distinct_color_histogram tdch_chk u_tdch_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_distinct (out_if.distinct_colors),
  .out_total    (out_if.cell_total),
  .out_last     (out_if.last_bin)
);

`default_nettype wire
